// ----- src/chmw_pkg.sv -----
// Shared types and constants for the convex hull minimum width block.
package chmw_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 16;

   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;

   localparam int MUL_A_BITS = 2 * PROD_BITS;
   localparam int MUL_B_BITS = PROD_BITS;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
   localparam int MUL_CNT_BITS = $clog2(MUL_B_BITS);

   localparam int NUM_OUT_BITS = 33;
   localparam int HULL_OUT_BITS = 11;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      point_type o;
      point_type b;
      point_type c;
      logic      len_mode;
   } cross_in_type;

   typedef struct packed {
      logic                  start;
      logic [MUL_A_BITS-1:0] a;
      logic [MUL_B_BITS-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [MUL_P_BITS-1:0] product;
   } mul_rsp_type;

endpackage

// ----- src/chmw_cross.sv -----
// Two-product unit: cross product (b-o)x(c-o) or squared length of b-o.
module chmw_cross
   import chmw_pkg::*;
(
   input  logic                         clock,
   input  cross_in_type                 cin,
   output logic signed [CROSS_BITS-1:0] cross_val
);

   logic signed [DIFF_BITS-1:0] bx, by, cx, cy, fa, fb;
   logic signed [PROD_BITS-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic                        mode_ff;

   always_comb begin
      bx = DIFF_BITS'(cin.b.x) - DIFF_BITS'(cin.o.x);
      by = DIFF_BITS'(cin.b.y) - DIFF_BITS'(cin.o.y);
      cx = DIFF_BITS'(cin.c.x) - DIFF_BITS'(cin.o.x);
      cy = DIFF_BITS'(cin.c.y) - DIFF_BITS'(cin.o.y);
      fa = cin.len_mode ? bx : cy;
      fb = cin.len_mode ? by : cx;
      prod_a_in = bx * fa;
      prod_b_in = by * fb;
   end

   always_ff @(posedge clock) begin
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      mode_ff   <= cin.len_mode;
   end

   assign cross_val = mode_ff ? (CROSS_BITS'(prod_a_ff) + CROSS_BITS'(prod_b_ff))
                              : (CROSS_BITS'(prod_a_ff) - CROSS_BITS'(prod_b_ff));

endmodule

// ----- src/chmw_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle.
module chmw_mul
   import chmw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic [MUL_P_BITS-1:0]   acc_ff, acc_in, mcand_ff, mcand_in;
   logic [MUL_B_BITS-1:0]   mplier_ff, mplier_in;
   logic [MUL_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (req.start) begin
         acc_in    = '0;
         mcand_in  = MUL_P_BITS'(req.a);
         mplier_in = req.b;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + MUL_CNT_BITS'(1);
         if (cnt_ff == MUL_CNT_BITS'(MUL_B_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
   end

   assign rsp.busy    = busy_ff;
   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

// ----- src/convex_hull_min_width.sv -----
// Top level: point store, sort, monotone chain hull and minimum width scan.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | x_coord, y_coord, last_point
//  rsp     | out       | rsp_valid / rsp_ready | width_numerator, edge_length_squared,
//          |           |                       | hull_size, set_empty
//
// Points load one per cycle. After the last point: insertion sort on the point
// memory (read, compare and shift down per point, n*(n-1)/2 shifts worst case),
// two hull passes (push each point, pop on a failed cross check), then per hull
// edge: squared length, cross product per vertex, serial multiplies for the width
// compare. req_ready is low from the last point until the result is loaded into the
// output register. No clearing pass: the memories are only read where written.
module convex_hull_min_width
   import chmw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [15:0]       req_x_coord,
   input  logic signed [15:0]       req_y_coord,
   input  logic                     req_last_point,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [NUM_OUT_BITS-1:0]  rsp_width_numerator,
   output logic [NUM_OUT_BITS-1:0]  rsp_edge_length_squared,
   output logic [HULL_OUT_BITS-1:0] rsp_hull_size,
   output logic                     rsp_set_empty
);

   typedef enum logic [21:0] {
      ST_LOAD     = 22'h000001,
      ST_SORT_RDV = 22'h000002,
      ST_SORT_V   = 22'h000004,
      ST_SORT_CMP = 22'h000008,
      ST_H_START  = 22'h000010,
      ST_H_RD     = 22'h000020,
      ST_H_P      = 22'h000040,
      ST_H_CHK    = 22'h000080,
      ST_H_CR     = 22'h000100,
      ST_H_POP    = 22'h000200,
      ST_H_END    = 22'h000400,
      ST_W_RDA    = 22'h000800,
      ST_W_A      = 22'h001000,
      ST_W_B      = 22'h002000,
      ST_W_LEN    = 22'h004000,
      ST_W_LENC   = 22'h008000,
      ST_W_CR     = 22'h010000,
      ST_W_CRC    = 22'h020000,
      ST_W_CMP    = 22'h040000,
      ST_W_MUL    = 22'h080000,
      ST_W_MULW   = 22'h100000,
      ST_OUT      = 22'h200000
   } state_type;

   localparam logic SEL_UPPER = 1'b0;
   localparam logic SEL_LOWER = 1'b1;

   // memories
   point_type pmem [MAX_POINTS];
   point_type cmem [2*MAX_POINTS];

   logic                pwe, cwe;
   logic [IDX_BITS-1:0] pwaddr, praddr;
   logic [IDX_BITS:0]   cwaddr, craddr;
   point_type           pwdata, cwdata, prd_ff, crd_ff;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in, n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic [CNT_BITS-1:0]     k_ff, k_in, s_ff, s_in, nu_ff, nu_in, nl_ff, nl_in;
   logic [CNT_BITS-1:0]     h_ff, h_in;
   logic                    pass_ff, pass_in;
   point_type               v_ff, v_in, p_ff, p_in, t1_ff, t1_in, t2_ff, t2_in;
   point_type               u0_ff, u0_in, u1_ff, u1_in, a_ff, a_in, b_ff, b_in;
   logic [PROD_BITS-1:0]    len_ff, len_in, mx_ff, mx_in;
   logic [PROD_BITS-1:0]    bestn_ff, bestn_in, bestl_ff, bestl_in;
   logic [MUL_A_BITS-1:0]   sq_ff, sq_in;
   logic [MUL_P_BITS-1:0]   pa_ff, pa_in;
   logic [1:0]              mstep_ff, mstep_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NUM_OUT_BITS-1:0] rnum_ff, rnum_in, rlen_ff, rlen_in;
   logic [HULL_OUT_BITS-1:0] rhull_ff, rhull_in;
   logic                    rempty_ff, rempty_in;

   cross_in_type                 cin;
   logic signed [CROSS_BITS-1:0] cross_val;
   mul_req_type                  mreq;
   mul_rsp_type                  mrsp;

   logic [CNT_BITS-1:0] new_cnt, jidx, hcalc;
   logic [CNT_BITS-1:0] i_prev, j_prev2, s_prev3;
   logic                do_push, pop;
   point_type           in_pt;

   function automatic logic pt_less(point_type a, point_type b);
      return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
   endfunction

   // hull vertex k: lower chain first, then upper chain reversed without its ends
   function automatic logic [IDX_BITS:0] haddr(logic [CNT_BITS-1:0] k,
                                                logic [CNT_BITS-1:0] nl,
                                                logic [CNT_BITS-1:0] h);
      logic [CNT_BITS-1:0] d;
      d = h - k;
      if (k < nl) return {SEL_LOWER, k[IDX_BITS-1:0]};
      return {SEL_UPPER, d[IDX_BITS-1:0]};
   endfunction

   chmw_cross u_cross (
      .clock     (clock),
      .cin       (cin),
      .cross_val (cross_val)
   );

   chmw_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   assign in_pt.x = req_x_coord[COORD_BITS-1:0];
   assign in_pt.y = req_y_coord[COORD_BITS-1:0];
   assign req_ready = (state_ff == ST_LOAD);
   assign jidx = (i_ff + CNT_BITS'(1) == h_ff) ? '0 : i_ff + CNT_BITS'(1);
   assign i_prev  = i_ff - CNT_BITS'(1);
   assign j_prev2 = j_ff - CNT_BITS'(2);
   assign s_prev3 = s_ff - CNT_BITS'(3);

   always_comb begin
      if (state_ff == ST_H_CHK) begin
         cin.o = t2_ff;
         cin.b = p_ff;
         cin.c = t1_ff;
      end else begin
         cin.o = a_ff;
         cin.b = b_ff;
         cin.c = crd_ff;
      end
      cin.len_mode = (state_ff == ST_W_LEN);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; n_in = n_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff;
      s_in = s_ff; nu_in = nu_ff; nl_in = nl_ff; h_in = h_ff; pass_in = pass_ff;
      v_in = v_ff; p_in = p_ff; t1_in = t1_ff; t2_in = t2_ff;
      u0_in = u0_ff; u1_in = u1_ff; a_in = a_ff; b_in = b_ff;
      len_in = len_ff; mx_in = mx_ff; bestn_in = bestn_ff; bestl_in = bestl_ff;
      sq_in = sq_ff; pa_in = pa_ff; mstep_in = mstep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rnum_in = rnum_ff; rlen_in = rlen_ff; rhull_in = rhull_ff; rempty_in = rempty_ff;
      pwe = 1'b0; pwaddr = cnt_ff[IDX_BITS-1:0]; pwdata = in_pt;
      praddr = i_ff[IDX_BITS-1:0];
      cwe = 1'b0; cwaddr = {pass_ff, s_ff[IDX_BITS-1:0]}; cwdata = p_ff;
      craddr = haddr(i_ff, nl_ff, h_ff);
      mreq.start = 1'b0;
      mreq.a = MUL_A_BITS'(mx_ff);
      mreq.b = mx_ff;
      new_cnt = cnt_ff;
      do_push = 1'b0;
      pop = 1'b0;
      hcalc = CNT_BITS'(s_ff + nu_ff - CNT_BITS'(2));

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (cnt_ff < CNT_BITS'(MAX_POINTS)) begin
                  pwe = 1'b1;
                  new_cnt = cnt_ff + CNT_BITS'(1);
               end
               cnt_in = new_cnt;
               if (req_last_point) begin
                  n_in = new_cnt;
                  cnt_in = '0;
                  bestn_in = '0;
                  bestl_in = '0;
                  pass_in = SEL_UPPER;
                  i_in = CNT_BITS'(1);
                  h_in = '0;
                  if (new_cnt == '0) state_in = ST_OUT;
                  else if (new_cnt > CNT_BITS'(1)) state_in = ST_SORT_RDV;
                  else state_in = ST_H_START;
               end
            end
         end
         ST_SORT_RDV: begin
            praddr = i_ff[IDX_BITS-1:0];
            state_in = ST_SORT_V;
         end
         ST_SORT_V: begin
            v_in = prd_ff;
            j_in = i_ff;
            praddr = i_prev[IDX_BITS-1:0];
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            pwe = 1'b1;
            pwaddr = j_ff[IDX_BITS-1:0];
            if (j_ff != '0 && pt_less(v_ff, prd_ff)) begin
               pwdata = prd_ff;
               j_in = j_ff - CNT_BITS'(1);
               praddr = j_prev2[IDX_BITS-1:0];
            end else begin
               pwdata = v_ff;
               if (i_ff + CNT_BITS'(1) < n_ff) begin
                  i_in = i_ff + CNT_BITS'(1);
                  state_in = ST_SORT_RDV;
               end else begin
                  state_in = ST_H_START;
               end
            end
         end
         ST_H_START: begin
            s_in = '0;
            k_in = '0;
            state_in = ST_H_RD;
         end
         ST_H_RD: begin
            praddr = k_ff[IDX_BITS-1:0];
            state_in = ST_H_P;
         end
         ST_H_P: begin
            p_in = prd_ff;
            state_in = ST_H_CHK;
         end
         ST_H_CHK: begin
            if (s_ff > CNT_BITS'(1)) state_in = ST_H_CR;
            else do_push = 1'b1;
         end
         ST_H_CR: begin
            pop = (pass_ff == SEL_UPPER) ? (cross_val <= 0) : (cross_val >= 0);
            if (pop) begin
               s_in = s_ff - CNT_BITS'(1);
               t1_in = t2_ff;
               craddr = {pass_ff, s_prev3[IDX_BITS-1:0]};
               state_in = (s_ff > CNT_BITS'(2)) ? ST_H_POP : ST_H_CHK;
            end else begin
               do_push = 1'b1;
            end
         end
         ST_H_POP: begin
            t2_in = crd_ff;
            state_in = ST_H_CHK;
         end
         ST_H_END: begin
            if (pass_ff == SEL_UPPER) begin
               nu_in = s_ff;
               pass_in = SEL_LOWER;
               state_in = ST_H_START;
            end else begin
               nl_in = s_ff;
               if (n_ff == CNT_BITS'(1) || u0_ff == u1_ff) h_in = CNT_BITS'(1);
               else h_in = hcalc;
               i_in = '0;
               if (n_ff != CNT_BITS'(1) && u0_ff != u1_ff && hcalc > CNT_BITS'(2))
                  state_in = ST_W_RDA;
               else
                  state_in = ST_OUT;
            end
         end
         ST_W_RDA: begin
            craddr = haddr(i_ff, nl_ff, h_ff);
            state_in = ST_W_A;
         end
         ST_W_A: begin
            a_in = crd_ff;
            craddr = haddr(jidx, nl_ff, h_ff);
            state_in = ST_W_B;
         end
         ST_W_B: begin
            b_in = crd_ff;
            state_in = ST_W_LEN;
         end
         ST_W_LEN: begin
            state_in = ST_W_LENC;
         end
         ST_W_LENC: begin
            len_in = cross_val[PROD_BITS-1:0];
            mx_in = '0;
            k_in = '0;
            craddr = haddr('0, nl_ff, h_ff);
            state_in = ST_W_CR;
         end
         ST_W_CR: begin
            state_in = ST_W_CRC;
         end
         ST_W_CRC: begin
            // vertices on the edge give zero and never win
            if (cross_val > 0 && cross_val > $signed({1'b0, mx_ff}))
               mx_in = cross_val[PROD_BITS-1:0];
            if (k_ff + CNT_BITS'(1) < h_ff) begin
               k_in = k_ff + CNT_BITS'(1);
               craddr = haddr(k_ff + CNT_BITS'(1), nl_ff, h_ff);
               state_in = ST_W_CR;
            end else begin
               state_in = ST_W_CMP;
            end
         end
         ST_W_CMP: begin
            if (i_ff == '0) begin
               bestn_in = mx_ff;
               bestl_in = len_ff;
               i_in = i_ff + CNT_BITS'(1);
               state_in = (i_ff + CNT_BITS'(1) < h_ff) ? ST_W_RDA : ST_OUT;
            end else begin
               mstep_in = '0;
               state_in = ST_W_MUL;
            end
         end
         ST_W_MUL: begin
            // mx*mx*bestl against bestn*bestn*len
            mreq.start = 1'b1;
            unique case (mstep_ff)
               2'd0: begin mreq.a = MUL_A_BITS'(mx_ff);    mreq.b = mx_ff;    end
               2'd1: begin mreq.a = sq_ff;                 mreq.b = bestl_ff; end
               2'd2: begin mreq.a = MUL_A_BITS'(bestn_ff); mreq.b = bestn_ff; end
               default: begin mreq.a = sq_ff;              mreq.b = len_ff;   end
            endcase
            state_in = ST_W_MULW;
         end
         ST_W_MULW: begin
            if (mrsp.done) begin
               mstep_in = mstep_ff + 2'd1;
               state_in = ST_W_MUL;
               unique case (mstep_ff)
                  2'd0, 2'd2: sq_in = mrsp.product[MUL_A_BITS-1:0];
                  2'd1: pa_in = mrsp.product;
                  default: begin
                     if (pa_ff < mrsp.product) begin
                        bestn_in = mx_ff;
                        bestl_in = len_ff;
                     end
                     i_in = i_ff + CNT_BITS'(1);
                     state_in = (i_ff + CNT_BITS'(1) < h_ff) ? ST_W_RDA : ST_OUT;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rnum_in = bestn_ff[NUM_OUT_BITS-1:0];
               rlen_in = bestl_ff[NUM_OUT_BITS-1:0];
               rhull_in = HULL_OUT_BITS'(h_ff);
               rempty_in = (n_ff == '0);
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase

      if (do_push) begin
         cwe = 1'b1;
         cwaddr = {pass_ff, s_ff[IDX_BITS-1:0]};
         cwdata = p_ff;
         t2_in = t1_ff;
         t1_in = p_ff;
         if (pass_ff == SEL_UPPER && s_ff == '0) u0_in = p_ff;
         if (pass_ff == SEL_UPPER && s_ff == CNT_BITS'(1)) u1_in = p_ff;
         s_in = s_ff + CNT_BITS'(1);
         if (k_ff + CNT_BITS'(1) < n_ff) begin
            k_in = k_ff + CNT_BITS'(1);
            state_in = ST_H_RD;
         end else begin
            state_in = ST_H_END;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pwe) pmem[pwaddr] <= pwdata;
      prd_ff <= pmem[praddr];
   end

   always_ff @(posedge clock) begin
      if (cwe) cmem[cwaddr] <= cwdata;
      crd_ff <= cmem[craddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in; i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; s_ff <= s_in;
      nu_ff <= nu_in; nl_ff <= nl_in; h_ff <= h_in; pass_ff <= pass_in;
      v_ff <= v_in; p_ff <= p_in; t1_ff <= t1_in; t2_ff <= t2_in;
      u0_ff <= u0_in; u1_ff <= u1_in; a_ff <= a_in; b_ff <= b_in;
      len_ff <= len_in; mx_ff <= mx_in; bestn_ff <= bestn_in; bestl_ff <= bestl_in;
      sq_ff <= sq_in; pa_ff <= pa_in; mstep_ff <= mstep_in;
      rnum_ff <= rnum_in; rlen_ff <= rlen_in; rhull_ff <= rhull_in;
      rempty_ff <= rempty_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_width_numerator     = rnum_ff;
   assign rsp_edge_length_squared = rlen_ff;
   assign rsp_hull_size           = rhull_ff;
   assign rsp_set_empty           = rempty_ff;

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      mreq.start |-> !mrsp.busy)
      else $error("multiplier started while busy");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_H_CHK || state_ff == ST_H_CR) |-> (s_ff <= n_ff))
      else $error("hull stack deeper than point set");

   a_edge_len: assert property (@(posedge clock) disable iff (reset)
      (state_in == ST_LOAD && state_ff == ST_OUT && h_ff > CNT_BITS'(2))
      |=> (rsp_edge_length_squared != '0))
      else $error("zero edge length on a proper hull");
`endif

endmodule

// ----- test/convex_hull_min_width_test.sv -----
// Testbench for convex_hull_min_width: directed and random sets checked against a hull predictor.
`timescale 1ns / 100ps

module convex_hull_min_width_test;
   import chmw_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               last;
   } point_item_type;

   typedef struct {
      logic [NUM_OUT_BITS-1:0]  numer;
      logic [NUM_OUT_BITS-1:0]  len_sq;
      logic [HULL_OUT_BITS-1:0] hull;
      logic                     empty;
   } width_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [15:0]       req_x_coord;
   logic signed [15:0]       req_y_coord;
   logic                     req_last_point;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [NUM_OUT_BITS-1:0]  rsp_width_numerator;
   logic [NUM_OUT_BITS-1:0]  rsp_edge_length_squared;
   logic [HULL_OUT_BITS-1:0] rsp_hull_size;
   logic                     rsp_set_empty;

   point_item_type   point_q[$];
   width_result_type width_q[$];
   int               send_idle_pct;
   int               recv_stall_pct;
   int               mismatch_count;
   int               quiet_cycles;

   // predictor state
   longint px[MAX_POINTS];
   longint py[MAX_POINTS];
   int     ord[MAX_POINTS];
   int     lo_chain[MAX_POINTS];
   int     up_chain[MAX_POINTS];
   int     hull_idx[MAX_POINTS];
   int     stored_count;

   convex_hull_min_width u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_width_numerator(rsp_width_numerator),
      .rsp_edge_length_squared(rsp_edge_length_squared),
      .rsp_hull_size(rsp_hull_size), .rsp_set_empty(rsp_set_empty)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint cross_of(int o, int b, int c);
      return (px[b] - px[o]) * (py[c] - py[o]) - (py[b] - py[o]) * (px[c] - px[o]);
   endfunction

   function automatic bit point_less(int a, int b);
      if (px[a] != px[b]) return px[a] < px[b];
      return py[a] < py[b];
   endfunction

   // n1 / sqrt(l1) < n2 / sqrt(l2), exact
   function automatic bit narrower(logic [127:0] n1, logic [127:0] l1,
                                   logic [127:0] n2, logic [127:0] l2);
      logic [127:0] lhs;
      logic [127:0] rhs;
      lhs = n1 * n1 * l2;
      rhs = n2 * n2 * l1;
      return lhs < rhs;
   endfunction

   function automatic int build_hull(int n);
      int i, j, v, nl, nu, h;
      nl = 0;
      nu = 0;
      h = 0;
      for (i = 0; i < n; i++) ord[i] = i;
      for (i = 1; i < n; i++) begin
         v = ord[i];
         j = i;
         while (j > 0 && point_less(v, ord[j-1])) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = v;
      end
      for (i = 0; i < n; i++) begin
         while (nu > 1 && cross_of(up_chain[nu-2], ord[i], up_chain[nu-1]) <= 0) nu--;
         up_chain[nu++] = ord[i];
         while (nl > 1 && cross_of(lo_chain[nl-2], ord[i], lo_chain[nl-1]) >= 0) nl--;
         lo_chain[nl++] = ord[i];
      end
      if (n <= 1) return n;
      if (px[up_chain[0]] == px[up_chain[1]] && py[up_chain[0]] == py[up_chain[1]])
         return 1;
      for (i = 0; i < nl && h < MAX_POINTS; i++) hull_idx[h++] = lo_chain[i];
      for (i = nu - 1; i >= 2 && h < MAX_POINTS; i--) hull_idx[h++] = up_chain[i-1];
      return h;
   endfunction

   function automatic void predict_point(point_item_type it);
      width_result_type r;
      int n, h, i, j, k, a, b;
      longint dx, dy, c, best_n, best_l, len, mx;
      if (stored_count < MAX_POINTS) begin
         px[stored_count] = it.x;
         py[stored_count] = it.y;
         stored_count++;
      end
      if (!it.last) return;
      n = stored_count;
      stored_count = 0;
      best_n = 0;
      best_l = 0;
      h = build_hull(n);
      if (h >= 3) begin
         for (i = 0; i < h; i++) begin
            j = (i + 1 == h) ? 0 : i + 1;
            a = hull_idx[i];
            b = hull_idx[j];
            dx = px[b] - px[a];
            dy = py[b] - py[a];
            len = dx * dx + dy * dy;
            mx = 0;
            for (k = 0; k < h; k++) begin
               if (k != i && k != j) begin
                  c = cross_of(a, b, hull_idx[k]);
                  if (c > mx) mx = c;
               end
            end
            if (i == 0 || narrower(mx, len, best_n, best_l)) begin
               best_n = mx;
               best_l = len;
            end
         end
      end
      r.numer = best_n[NUM_OUT_BITS-1:0];
      r.len_sq = best_l[NUM_OUT_BITS-1:0];
      r.hull = h[HULL_OUT_BITS-1:0];
      r.empty = (n == 0);
      width_q.insert(width_q.size(), r);
   endfunction

   task automatic add_point(int x, int y, bit last);
      point_item_type it;
      it.x = x[15:0];
      it.y = y[15:0];
      it.last = last;
      point_q.insert(point_q.size(), it);
   endtask

   function automatic int pick_coord(int mode);
      case (mode)
         0: return $signed($urandom() & 32'hFFFF) <<< 16 >>> 16;
         1: return $urandom_range(16) - 8;
         2: begin
            case ($urandom_range(2))
               0: return -32768;
               1: return 32767;
               default: return 0;
            endcase
         end
         default: return $urandom_range(2000) - 1000;
      endcase
   endfunction

   task automatic add_random_set();
      int n, mode, i;
      n = ($urandom_range(39) == 0) ? 60 : $urandom_range(24, 1);
      mode = $urandom_range(3);
      for (i = 0; i < n; i++)
         add_point(pick_coord(mode), pick_coord(mode), i == n - 1);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_x_coord <= '0;
         req_y_coord <= '0;
         req_last_point <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            point_item_type acc;
            acc.x = req_x_coord;
            acc.y = req_y_coord;
            acc.last = req_last_point;
            predict_point(acc);
         end
         if (!req_valid || req_ready) begin
            if (point_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               point_item_type nx;
               nx = point_q.pop_front();
               req_valid <= 1'b1;
               req_x_coord <= nx.x;
               req_y_coord <= nx.y;
               req_last_point <= nx.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (width_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected result item");
            end else begin
               width_result_type e;
               e = width_q.pop_front();
               if (e.numer !== rsp_width_numerator || e.len_sq !== rsp_edge_length_squared ||
                   e.hull !== rsp_hull_size || e.empty !== rsp_set_empty) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp num %0d len %0d hull %0d empty %0d, got %0d %0d %0d %0d",
                              e.numer, e.len_sq, e.hull, e.empty, rsp_width_numerator,
                              rsp_edge_length_squared, rsp_hull_size, rsp_set_empty);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic finish_phase();
      while (point_q.size() > 0 || req_valid || width_q.size() > 0) @(posedge clock);
   endtask

   initial begin
      int phase, i, quota;
      reset = 1'b1;
      req_valid = 1'b0;
      req_x_coord = '0;
      req_y_coord = '0;
      req_last_point = 1'b0;
      rsp_ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      quiet_cycles = 0;
      stored_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single point, pair, duplicates, collinear, extreme triangle, extreme square (ties)
      add_point(5, -7, 1);
      add_point(-32768, 32767, 0); add_point(32767, -32768, 1);
      add_point(3, 3, 0); add_point(3, 3, 0); add_point(3, 3, 1);
      add_point(0, 0, 0); add_point(2, 2, 0); add_point(1, 1, 0); add_point(-4, -4, 1);
      add_point(-32768, -32768, 0); add_point(32767, -32768, 0); add_point(-32768, 32767, 1);
      add_point(-32768, -32768, 0); add_point(32767, -32768, 0);
      add_point(32767, 32767, 0); add_point(-32768, 32767, 0); add_point(0, 0, 1);
      add_point(0, 0, 0); add_point(4, 0, 0); add_point(4, 4, 0); add_point(2, 2, 0);
      add_point(-1, 5, 1);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         quota = point_q.size() + 160;
         while (point_q.size() < quota) add_random_set();
         if (phase == 3) begin
            // overflow: points past capacity are dropped, already sorted to keep it fast
            for (i = 0; i < MAX_POINTS + 6; i++) add_point(i - 600, 2 * i - 1000, 0);
            add_point(-32768, 32767, 1);
         end
         finish_phase();
      end
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && width_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
